// ----- design/shtd_pkg.sv -----
// ----------------------------------------------------------------------------
// shtd_pkg
// Types, constants and the code tree ROM of the static Huffman text decoder.
// ----------------------------------------------------------------------------
package shtd_pkg;

  localparam int NODE_COUNT = 189;
  localparam logic [7:0] NODE_LIMIT = 8'(NODE_COUNT);
  localparam logic [2:0] HDR_BYTES = 3'd4;

  typedef struct packed {
    logic [7:0] lo;
    logic [7:0] hi;
    logic [6:0] ch;
  } rom_entry_t;

  typedef struct packed {
    logic load;
    logic step;
    logic flush;
  } shtd_cmd_t;

  typedef struct packed {
    logic hdr_phase;
    logic left_zero;
    logic left_one;
    logic last_bit;
    logic leaf;
    logic pend_valid;
    logic out_free;
  } shtd_sts_t;

  localparam rom_entry_t CODE_ROM [NODE_COUNT] = '{
    '{8'd1, 8'd116, 7'd0},   '{8'd2, 8'd67, 7'd0},    '{8'd3, 8'd66, 7'd0},
    '{8'd4, 8'd63, 7'd0},    '{8'd5, 8'd62, 7'd0},    '{8'd6, 8'd9, 7'd0},
    '{8'd7, 8'd8, 7'd0},     '{8'd0, 8'd0, 7'd34},    '{8'd0, 8'd0, 7'd51},
    '{8'd10, 8'd39, 7'd0},   '{8'd11, 8'd18, 7'd0},   '{8'd12, 8'd17, 7'd0},
    '{8'd13, 8'd16, 7'd0},   '{8'd14, 8'd15, 7'd0},   '{8'd0, 8'd0, 7'd106},
    '{8'd0, 8'd0, 7'd76},    '{8'd0, 8'd0, 7'd69},    '{8'd0, 8'd0, 7'd60},
    '{8'd19, 8'd38, 7'd0},   '{8'd20, 8'd37, 7'd0},   '{8'd21, 8'd36, 7'd0},
    '{8'd22, 8'd23, 7'd0},   '{8'd0, 8'd0, 7'd85},    '{8'd24, 8'd25, 7'd0},
    '{8'd0, 8'd0, 7'd38},    '{8'd26, 8'd27, 7'd0},   '{8'd0, 8'd0, 7'd75},
    '{8'd28, 8'd29, 7'd0},   '{8'd0, 8'd0, 7'd64},    '{8'd30, 8'd31, 7'd0},
    '{8'd0, 8'd0, 7'd89},    '{8'd32, 8'd35, 7'd0},   '{8'd33, 8'd34, 7'd0},
    '{8'd0, 8'd0, 7'd33},    '{8'd0, 8'd0, 7'd96},    '{8'd0, 8'd0, 7'd88},
    '{8'd0, 8'd0, 7'd68},    '{8'd0, 8'd0, 7'd73},    '{8'd0, 8'd0, 7'd37},
    '{8'd40, 8'd59, 7'd0},   '{8'd41, 8'd42, 7'd0},   '{8'd0, 8'd0, 7'd62},
    '{8'd43, 8'd50, 7'd0},   '{8'd44, 8'd45, 7'd0},   '{8'd0, 8'd0, 7'd124},
    '{8'd46, 8'd47, 7'd0},   '{8'd0, 8'd0, 7'd122},   '{8'd48, 8'd49, 7'd0},
    '{8'd0, 8'd0, 7'd78},    '{8'd0, 8'd0, 7'd87},    '{8'd51, 8'd54, 7'd0},
    '{8'd52, 8'd53, 7'd0},   '{8'd0, 8'd0, 7'd72},    '{8'd0, 8'd0, 7'd71},
    '{8'd55, 8'd56, 7'd0},   '{8'd0, 8'd0, 7'd86},    '{8'd57, 8'd58, 7'd0},
    '{8'd0, 8'd0, 7'd66},    '{8'd0, 8'd0, 7'd36},    '{8'd60, 8'd61, 7'd0},
    '{8'd0, 8'd0, 7'd123},   '{8'd0, 8'd0, 7'd125},   '{8'd0, 8'd0, 7'd61},
    '{8'd64, 8'd65, 7'd0},   '{8'd0, 8'd0, 7'd102},   '{8'd0, 8'd0, 7'd48},
    '{8'd0, 8'd0, 7'd32},    '{8'd68, 8'd101, 7'd0},  '{8'd69, 8'd72, 7'd0},
    '{8'd70, 8'd71, 7'd0},   '{8'd0, 8'd0, 7'd46},    '{8'd0, 8'd0, 7'd44},
    '{8'd73, 8'd98, 7'd0},   '{8'd74, 8'd83, 7'd0},   '{8'd75, 8'd76, 7'd0},
    '{8'd0, 8'd0, 7'd50},    '{8'd77, 8'd78, 7'd0},   '{8'd0, 8'd0, 7'd118},
    '{8'd79, 8'd80, 7'd0},   '{8'd0, 8'd0, 7'd56},    '{8'd81, 8'd82, 7'd0},
    '{8'd0, 8'd0, 7'd35},    '{8'd0, 8'd0, 7'd83},    '{8'd84, 8'd97, 7'd0},
    '{8'd85, 8'd86, 7'd0},   '{8'd0, 8'd0, 7'd58},    '{8'd87, 8'd88, 7'd0},
    '{8'd0, 8'd0, 7'd92},    '{8'd89, 8'd92, 7'd0},   '{8'd90, 8'd91, 7'd0},
    '{8'd0, 8'd0, 7'd70},    '{8'd0, 8'd0, 7'd80},    '{8'd93, 8'd94, 7'd0},
    '{8'd0, 8'd0, 7'd47},    '{8'd95, 8'd96, 7'd0},   '{8'd0, 8'd0, 7'd126},
    '{8'd0, 8'd0, 7'd82},    '{8'd0, 8'd0, 7'd54},    '{8'd99, 8'd100, 7'd0},
    '{8'd0, 8'd0, 7'd95},    '{8'd0, 8'd0, 7'd39},    '{8'd102, 8'd113, 7'd0},
    '{8'd103, 8'd110, 7'd0}, '{8'd104, 8'd105, 7'd0}, '{8'd0, 8'd0, 7'd49},
    '{8'd106, 8'd107, 7'd0}, '{8'd0, 8'd0, 7'd98},    '{8'd108, 8'd109, 7'd0},
    '{8'd0, 8'd0, 7'd119},   '{8'd0, 8'd0, 7'd120},   '{8'd111, 8'd112, 7'd0},
    '{8'd0, 8'd0, 7'd53},    '{8'd0, 8'd0, 7'd112},   '{8'd114, 8'd115, 7'd0},
    '{8'd0, 8'd0, 7'd97},    '{8'd0, 8'd0, 7'd114},   '{8'd117, 8'd174, 7'd0},
    '{8'd118, 8'd145, 7'd0}, '{8'd119, 8'd130, 7'd0}, '{8'd120, 8'd121, 7'd0},
    '{8'd0, 8'd0, 7'd108},   '{8'd122, 8'd129, 7'd0}, '{8'd123, 8'd126, 7'd0},
    '{8'd124, 8'd125, 7'd0}, '{8'd0, 8'd0, 7'd57},    '{8'd0, 8'd0, 7'd45},
    '{8'd127, 8'd128, 7'd0}, '{8'd0, 8'd0, 7'd107},   '{8'd0, 8'd0, 7'd93},
    '{8'd0, 8'd0, 7'd117},   '{8'd131, 8'd144, 7'd0}, '{8'd132, 8'd143, 7'd0},
    '{8'd133, 8'd134, 7'd0}, '{8'd0, 8'd0, 7'd103},   '{8'd135, 8'd136, 7'd0},
    '{8'd0, 8'd0, 7'd91},    '{8'd137, 8'd142, 7'd0}, '{8'd138, 8'd139, 7'd0},
    '{8'd0, 8'd0, 7'd43},    '{8'd140, 8'd141, 7'd0}, '{8'd0, 8'd0, 7'd84},
    '{8'd0, 8'd0, 7'd67},    '{8'd0, 8'd0, 7'd52},    '{8'd0, 8'd0, 7'd104},
    '{8'd0, 8'd0, 7'd115},   '{8'd146, 8'd147, 7'd0}, '{8'd0, 8'd0, 7'd101},
    '{8'd148, 8'd171, 7'd0}, '{8'd149, 8'd170, 7'd0}, '{8'd150, 8'd151, 7'd0},
    '{8'd0, 8'd0, 7'd121},   '{8'd152, 8'd153, 7'd0}, '{8'd0, 8'd0, 7'd77},
    '{8'd154, 8'd155, 7'd0}, '{8'd0, 8'd0, 7'd55},    '{8'd156, 8'd157, 7'd0},
    '{8'd0, 8'd0, 7'd113},   '{8'd158, 8'd167, 7'd0}, '{8'd159, 8'd160, 7'd0},
    '{8'd0, 8'd0, 7'd42},    '{8'd161, 8'd166, 7'd0}, '{8'd162, 8'd163, 7'd0},
    '{8'd0, 8'd0, 7'd81},    '{8'd164, 8'd165, 7'd0}, '{8'd0, 8'd0, 7'd94},
    '{8'd0, 8'd0, 7'd63},    '{8'd0, 8'd0, 7'd79},    '{8'd168, 8'd169, 7'd0},
    '{8'd0, 8'd0, 7'd59},    '{8'd0, 8'd0, 7'd65},    '{8'd0, 8'd0, 7'd41},
    '{8'd172, 8'd173, 7'd0}, '{8'd0, 8'd0, 7'd40},    '{8'd0, 8'd0, 7'd99},
    '{8'd175, 8'd180, 7'd0}, '{8'd176, 8'd177, 7'd0}, '{8'd0, 8'd0, 7'd9},
    '{8'd178, 8'd179, 7'd0}, '{8'd0, 8'd0, 7'd105},   '{8'd0, 8'd0, 7'd111},
    '{8'd181, 8'd184, 7'd0}, '{8'd182, 8'd183, 7'd0}, '{8'd0, 8'd0, 7'd10},
    '{8'd0, 8'd0, 7'd110},   '{8'd185, 8'd188, 7'd0}, '{8'd186, 8'd187, 7'd0},
    '{8'd0, 8'd0, 7'd100},   '{8'd0, 8'd0, 7'd109},   '{8'd0, 8'd0, 7'd116}
  };

endpackage

// ----- design/shtd_if.sv -----
// ----------------------------------------------------------------------------
// shtd_if
// Valid/ready channels of the decoder: compressed input and decoded output.
// ----------------------------------------------------------------------------
interface shtd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;
  logic       message_start;

  modport source (output valid, output stream_byte, output message_start, input ready);
  modport sink   (input valid, input stream_byte, input message_start, output ready);
endinterface

interface shtd_out_if;
  logic        valid;
  logic        ready;
  logic [6:0]  character;
  logic [31:0] message_length;
  logic        message_end;
  logic        last_of_run;

  modport source (output valid, output character, output message_length,
                  output message_end, output last_of_run, input ready);
  modport sink   (input valid, input character, input message_length,
                  input message_end, input last_of_run, output ready);
endinterface

// ----- design/static_huffman_text_decoder_top.sv -----
// ----------------------------------------------------------------------------
// static_huffman_text_decoder_top
// Static Huffman text decoder with a fixed 189-node code tree.
// ----------------------------------------------------------------------------
// Words arrive one byte at a time; the first four bytes of a message (or the
// first four after reset) are a little-endian character count, later bytes
// are decoded MSB first through the tree ROM, one tree step per clock unless
// the output stalls. Header bytes and bytes past the count are accepted
// without a walk. A data byte is accepted, then walked one bit per step (all
// eight, fewer once the count runs out), then the last character of the byte
// is released with last_of_run set. That release needs one character of
// lookahead, so a character leaves only when the next one is found or the
// byte ends. A stalled output holds the walk and the release.
// ----------------------------------------------------------------------------
module static_huffman_text_decoder_top
  import shtd_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  shtd_in_if.sink       in_chan,
  shtd_out_if.source    out_chan
);

  shtd_cmd_t cmd;
  shtd_sts_t sts;

  shtd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  shtd_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_byte            (in_chan.stream_byte),
    .in_start           (in_chan.message_start),
    .cmd                (cmd),
    .sts                (sts),
    .out_valid          (out_chan.valid),
    .out_ready          (out_chan.ready),
    .out_character      (out_chan.character),
    .out_message_length (out_chan.message_length),
    .out_message_end    (out_chan.message_end),
    .out_last_of_run    (out_chan.last_of_run)
  );

endmodule

// ----- design/shtd_ctrl.sv -----
// ----------------------------------------------------------------------------
// shtd_ctrl
// Controller: accepts words, sequences the bit walk and the final flush.
// ----------------------------------------------------------------------------
module shtd_ctrl
  import shtd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  shtd_sts_t sts,
  output shtd_cmd_t cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_WALK  = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       stall;

  // a leaf found while a character is still pending needs a free output slot
  assign stall = sts.leaf && sts.pend_valid && !sts.out_free;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (!sts.hdr_phase && !sts.left_zero) state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (!stall) begin
          cmd.step = 1'b1;
          if (sts.last_bit || (sts.leaf && sts.left_one)) state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!sts.pend_valid) begin
          state_nxt = S_IDLE;
        end else if (sts.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

// ----- design/shtd_datapath.sv -----
// ----------------------------------------------------------------------------
// shtd_datapath
// Header count, tree walk over the ROM, pending character and output register.
// ----------------------------------------------------------------------------
module shtd_datapath
  import shtd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  in_byte,
  input  logic        in_start,
  input  shtd_cmd_t   cmd,
  output shtd_sts_t   sts,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  out_character,
  output logic [31:0] out_message_length,
  output logic        out_message_end,
  output logic        out_last_of_run
);

  logic [7:0]  node_r, node_nxt;
  logic [2:0]  hdr_r, hdr_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] left_r, left_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic [2:0]  bit_r, bit_nxt;
  logic        pend_valid_r, pend_valid_nxt;
  logic [6:0]  pend_ch_r, pend_ch_nxt;
  logic        pend_end_r, pend_end_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [6:0]  out_ch_r, out_ch_nxt;
  logic [31:0] out_len_r, out_len_nxt;
  logic        out_end_r, out_end_nxt;
  logic        out_last_r, out_last_nxt;

  logic [2:0]  base_hdr;
  logic [31:0] base_len;
  logic [7:0]  cur;
  logic [7:0]  next_idx;
  logic [6:0]  leaf_ch;
  logic        leaf;
  logic        out_free;
  logic        push;

  always_comb begin
    base_hdr = in_start ? 3'd0 : hdr_r;
    base_len = in_start ? 32'd0 : len_r;
    cur      = (node_r >= NODE_LIMIT) ? 8'd0 : node_r;
    next_idx = byte_r[7] ? CODE_ROM[cur].hi : CODE_ROM[cur].lo;
    if (next_idx >= NODE_LIMIT) next_idx = 8'd0;
    leaf_ch  = CODE_ROM[next_idx].ch;
    leaf     = (leaf_ch != 7'd0);
    out_free = !out_valid_r || out_ready;
    push     = cmd.flush ? pend_valid_r : (cmd.step && leaf && pend_valid_r);
  end

  always_comb begin
    sts.hdr_phase  = (base_hdr < HDR_BYTES);
    sts.left_zero  = (left_r == 32'd0);
    sts.left_one   = (left_r == 32'd1);
    sts.last_bit   = (bit_r == 3'd7);
    sts.leaf       = leaf;
    sts.pend_valid = pend_valid_r;
    sts.out_free   = out_free;
  end

  always_comb begin
    node_nxt       = node_r;
    hdr_nxt        = hdr_r;
    len_nxt        = len_r;
    left_nxt       = left_r;
    byte_nxt       = byte_r;
    bit_nxt        = bit_r;
    pend_valid_nxt = pend_valid_r;
    pend_ch_nxt    = pend_ch_r;
    pend_end_nxt   = pend_end_r;

    if (cmd.load) begin
      if (in_start) begin
        node_nxt = 8'd0;
        left_nxt = 32'd0;
      end
      hdr_nxt = base_hdr;
      len_nxt = base_len;
      if (base_hdr < HDR_BYTES) begin
        unique case (base_hdr[1:0])
          2'd0: len_nxt[7:0]   = base_len[7:0]   | in_byte;
          2'd1: len_nxt[15:8]  = base_len[15:8]  | in_byte;
          2'd2: len_nxt[23:16] = base_len[23:16] | in_byte;
          2'd3: len_nxt[31:24] = base_len[31:24] | in_byte;
          default: len_nxt = base_len;
        endcase
        hdr_nxt = base_hdr + 3'd1;
        if (hdr_nxt == HDR_BYTES) begin
          left_nxt = len_nxt;
          node_nxt = 8'd0;
        end
      end else begin
        byte_nxt = in_byte;
        bit_nxt  = 3'd0;
      end
    end

    if (cmd.step) begin
      byte_nxt = {byte_r[6:0], 1'b0};
      bit_nxt  = bit_r + 3'd1;
      if (leaf) begin
        left_nxt       = left_r - 32'd1;
        node_nxt       = 8'd0;
        pend_valid_nxt = 1'b1;
        pend_ch_nxt    = leaf_ch;
        pend_end_nxt   = (left_r == 32'd1);
      end else begin
        node_nxt = next_idx;
      end
    end

    if (cmd.flush) pend_valid_nxt = 1'b0;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_ch_nxt    = out_ch_r;
    out_len_nxt   = out_len_r;
    out_end_nxt   = out_end_r;
    out_last_nxt  = out_last_r;
    if (push) begin
      out_valid_nxt = 1'b1;
      out_ch_nxt    = pend_ch_r;
      out_len_nxt   = len_r;
      out_end_nxt   = pend_end_r;
      out_last_nxt  = cmd.flush;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_r       <= 8'd0;
      hdr_r        <= 3'd0;
      len_r        <= 32'd0;
      left_r       <= 32'd0;
      bit_r        <= 3'd0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      node_r       <= node_nxt;
      hdr_r        <= hdr_nxt;
      len_r        <= len_nxt;
      left_r       <= left_nxt;
      bit_r        <= bit_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r     <= byte_nxt;
    pend_ch_r  <= pend_ch_nxt;
    pend_end_r <= pend_end_nxt;
    out_ch_r   <= out_ch_nxt;
    out_len_r  <= out_len_nxt;
    out_end_r  <= out_end_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_character      = out_ch_r;
  assign out_message_length = out_len_r;
  assign out_message_end    = out_end_r;
  assign out_last_of_run    = out_last_r;

endmodule
